### sv/noc_packet_to_flit_injector_core_macros.svh
// assertion macros used by the checker file
`ifndef NOC_PACKET_TO_FLIT_INJECTOR_CORE_MACROS_SVH
`define NOC_PACKET_TO_FLIT_INJECTOR_CORE_MACROS_SVH

// antecedent in this cycle implies consequent in the next one
`define NFI_ASSERT_NEXT(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error("nfi check failed");

// antecedent implies consequent in the same cycle
`define NFI_ASSERT_SAME(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error("nfi check failed");

`endif

### sv/nfi_pkg.sv
// shared constants and types of the flit injector
package nfi_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_VCS     = 4;
   localparam int MAX_FLITS   = 63;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CH_W        = 2;
   localparam int LEN_W       = 6;
   localparam int PADDR_W     = 3;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_SENT  = 2'd1;
   localparam logic [1:0] ST_STALL = 2'd2;
   localparam logic [1:0] ST_DROP  = 2'd3;

   localparam logic [1:0] FK_HEAD = 2'd0;
   localparam logic [1:0] FK_BODY = 2'd1;
   localparam logic [1:0] FK_TAIL = 2'd2;

   localparam logic REG_INJ_DIS = 1'b0;

   typedef struct packed {
      logic [7:0]        source;
      logic [7:0]        dest;
      logic [CH_W-1:0]   channel;
      logic [LEN_W-1:0]  len;
      logic [31:0]       stamp;
      logic [2:0]        pkind;
      logic signed [31:0] word;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

### sv/noc_packet_to_flit_injector_core.sv
// top level of the flit injector: packet queue as a row of cells, flit cutter
// Usage:
//   A command beat is taken at a clock edge with start high and busy low.
//   busy stays low, so a beat may be given in every cycle. req_cmd selects
//   a push (packet into the queue) or a tick (one transmit attempt).
//   Every beat gives exactly one result beat, shown on the rsp_ ports with
//   rsp_valid high for one cycle, in the cycle after the command was taken.
//   Throughput is one beat per cycle: the head packet always sits in cell 0
//   of the row, and a pop moves every cell down by one in the same edge.
//   The receiver cannot hold results off; each result is there one cycle.
//   Reset (synchronous) empties the queue, clears the flit count, the request
//   level and the injection-disabled register; queue cells keep stale data,
//   which is never read at unoccupied slots. pready is always high. The
//   APB-style port holds one register at address 0, injection_disabled, which
//   the user writes only while no command is in flight, unenforced by the block.
module noc_packet_to_flit_injector_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [7:0]                        req_source_node,
   input  logic [7:0]                        req_dest_node,
   input  logic [nfi_pkg::CH_W-1:0]          req_channel,
   input  logic [31:0]                       req_birth_time,
   input  logic [nfi_pkg::LEN_W-1:0]         req_length_flits,
   input  logic [2:0]                        req_kind,
   input  logic signed [31:0]                req_word,
   input  logic                              req_ack_level,
   input  logic [nfi_pkg::NUM_VCS-1:0]       req_full_mask,
   input  logic [31:0]                       req_cycle_now,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [7:0]                        rsp_flit_source,
   output logic [7:0]                        rsp_flit_dest,
   output logic [nfi_pkg::CH_W-1:0]          rsp_flit_channel,
   output logic [31:0]                       rsp_flit_time,
   output logic [nfi_pkg::LEN_W-1:0]         rsp_seq_index,
   output logic [nfi_pkg::LEN_W-1:0]         rsp_seq_total,
   output logic [1:0]                        rsp_flit_kind,
   output logic [2:0]                        rsp_flit_payload_kind,
   output logic signed [31:0]                rsp_flit_payload_word,
   output logic                              rsp_req_level,
   output logic [31:0]                       rsp_latency,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nfi_pkg::PADDR_W-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int DEPTH = nfi_pkg::QUEUE_DEPTH;
   localparam int IDX_W = nfi_pkg::IDX_W;
   localparam int OCC_W = nfi_pkg::OCC_W;
   localparam int LEN_W = nfi_pkg::LEN_W;
   localparam int CH_W  = nfi_pkg::CH_W;

   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             level_ff, level_in;
   logic             dis_ff, dis_in;
   logic             valid_ff;

   logic [1:0]        status_ff, status_in;
   logic [7:0]        fsrc_ff, fsrc_in;
   logic [7:0]        fdst_ff, fdst_in;
   logic [CH_W-1:0]   fch_ff, fch_in;
   logic [31:0]       ftime_ff, ftime_in;
   logic [LEN_W-1:0]  sidx_ff, sidx_in;
   logic [LEN_W-1:0]  stot_ff, stot_in;
   logic [1:0]        fkind_ff, fkind_in;
   logic [2:0]        pkind_ff, pkind_in;
   logic signed [31:0] pword_ff, pword_in;
   logic [31:0]       lat_ff, lat_in;

   logic                  accept;
   logic                  push_ok;
   logic                  pop;
   logic [LEN_W-1:0]      rem_cur;
   logic [LEN_W-1:0]      push_len;
   nfi_pkg::entry_type    new_entry;
   nfi_pkg::entry_type    cells [DEPTH];
   nfi_pkg::cell_ctl_type ctl [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign pready = 1'b1;

   // config register
   always_comb begin
      dis_in = dis_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == nfi_pkg::REG_INJ_DIS)) begin
         dis_in = pwdata[0];
      end
   end
   assign prdata = (paddr[2] == nfi_pkg::REG_INJ_DIS) ? {31'b0, dis_ff} : 32'b0;

   // clamp and fold the pushed route fields
   always_comb begin
      push_len = req_length_flits;
      if (push_len == '0) begin
         push_len = LEN_W'(1);
      end else if (32'(push_len) > nfi_pkg::MAX_FLITS) begin
         push_len = LEN_W'(nfi_pkg::MAX_FLITS);
      end
      new_entry.source  = req_source_node;
      new_entry.dest    = req_dest_node;
      new_entry.channel = CH_W'(32'(req_channel) % nfi_pkg::NUM_VCS);
      new_entry.len     = push_len;
      new_entry.stamp   = req_birth_time;
      new_entry.pkind   = req_kind;
      new_entry.word    = req_word;
   end

   always_comb begin
      occ_in    = occ_ff;
      rem_in    = rem_ff;
      level_in  = level_ff;
      push_ok   = 1'b0;
      pop       = 1'b0;
      rem_cur   = '0;
      status_in = nfi_pkg::ST_NONE;
      fsrc_in   = '0;
      fdst_in   = '0;
      fch_in    = '0;
      ftime_in  = '0;
      sidx_in   = '0;
      stot_in   = '0;
      fkind_in  = nfi_pkg::FK_HEAD;
      pkind_in  = '0;
      pword_in  = '0;
      lat_in    = '0;
      if (accept) begin
         if (req_cmd == nfi_pkg::CMD_PUSH) begin
            if (32'(occ_ff) >= DEPTH) begin
               status_in = nfi_pkg::ST_DROP;
            end else begin
               push_ok = 1'b1;
               occ_in  = occ_ff + OCC_W'(1);
            end
         end else begin
            // unstarted head while disabled: drop the whole queue first
            if ((occ_ff != '0) && (rem_ff == '0) && dis_ff) begin
               occ_in = '0;
               rem_in = '0;
            end
            if ((occ_in != '0) && (req_ack_level == level_ff)) begin
               if (req_full_mask[cells[0].channel]) begin
                  status_in = nfi_pkg::ST_STALL;
                  fch_in    = cells[0].channel;
               end else begin
                  rem_cur   = (rem_ff == '0) ? cells[0].len : rem_ff;
                  status_in = nfi_pkg::ST_SENT;
                  fsrc_in   = cells[0].source;
                  fdst_in   = cells[0].dest;
                  fch_in    = cells[0].channel;
                  ftime_in  = cells[0].stamp;
                  sidx_in   = cells[0].len - rem_cur;
                  stot_in   = cells[0].len;
                  pkind_in  = cells[0].pkind;
                  pword_in  = cells[0].word;
                  lat_in    = req_cycle_now - cells[0].stamp;
                  if (rem_cur == cells[0].len) begin
                     fkind_in = nfi_pkg::FK_HEAD;
                  end else if (rem_cur == LEN_W'(1)) begin
                     fkind_in = nfi_pkg::FK_TAIL;
                  end else begin
                     fkind_in = nfi_pkg::FK_BODY;
                  end
                  level_in = !level_ff;
                  if (rem_cur == LEN_W'(1)) begin
                     pop    = 1'b1;
                     rem_in = '0;
                     occ_in = dis_ff ? '0 : (occ_ff - OCC_W'(1));
                  end else begin
                     rem_in = rem_cur - LEN_W'(1);
                  end
               end
            end
         end
      end
   end

   // row of queue cells, head in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctl[i].load  = push_ok && (occ_ff[IDX_W-1:0] == IDX_W'(i));
      assign ctl[i].shift = pop;
      if (i == DEPTH - 1) begin : g_last
         nfi_cell u_cell (
            .clock     (clock),
            .ctl       (ctl[i]),
            .load_data (new_entry),
            .next_data (cells[i]),
            .data      (cells[i])
         );
      end else begin : g_mid
         nfi_cell u_cell (
            .clock     (clock),
            .ctl       (ctl[i]),
            .load_data (new_entry),
            .next_data (cells[i+1]),
            .data      (cells[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         rem_ff   <= '0;
         level_ff <= 1'b0;
         dis_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         occ_ff   <= occ_in;
         rem_ff   <= rem_in;
         level_ff <= level_in;
         dis_ff   <= dis_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      fsrc_ff   <= fsrc_in;
      fdst_ff   <= fdst_in;
      fch_ff    <= fch_in;
      ftime_ff  <= ftime_in;
      sidx_ff   <= sidx_in;
      stot_ff   <= stot_in;
      fkind_ff  <= fkind_in;
      pkind_ff  <= pkind_in;
      pword_ff  <= pword_in;
      lat_ff    <= lat_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_flit_source       = fsrc_ff;
   assign rsp_flit_dest         = fdst_ff;
   assign rsp_flit_channel      = fch_ff;
   assign rsp_flit_time         = ftime_ff;
   assign rsp_seq_index         = sidx_ff;
   assign rsp_seq_total         = stot_ff;
   assign rsp_flit_kind         = fkind_ff;
   assign rsp_flit_payload_kind = pkind_ff;
   assign rsp_flit_payload_word = pword_ff;
   assign rsp_req_level         = level_ff;
   assign rsp_latency           = lat_ff;

endmodule

### sv/nfi_cell.sv
// one queue slot: loads a new packet or takes its upper neighbor on a pop
module nfi_cell (
   input  logic                  clock,
   input  nfi_pkg::cell_ctl_type ctl,
   input  nfi_pkg::entry_type    load_data,
   input  nfi_pkg::entry_type    next_data,
   output nfi_pkg::entry_type    data
);

   nfi_pkg::entry_type data_ff;
   nfi_pkg::entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### sv/nfi_checker.sv
// port-level checks of the flit injector, bound to the top level
`include "noc_packet_to_flit_injector_core_macros.svh"

module nfi_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [5:0]  rsp_seq_total,
   input logic [31:0] rsp_latency
);

   // one result beat for each command beat, in the cycle after it
   `NFI_ASSERT_NEXT(a_rsp_follows, start && !busy, rsp_valid)
   `NFI_ASSERT_NEXT(a_no_spurious, !(start && !busy), !rsp_valid)
   // a drop only answers a push, a sent flit or a stall only a tick
   `NFI_ASSERT_NEXT(a_drop_push, start && !busy && (req_cmd == nfi_pkg::CMD_TICK), rsp_status != nfi_pkg::ST_DROP)
   `NFI_ASSERT_NEXT(a_sent_tick, start && !busy && (req_cmd == nfi_pkg::CMD_PUSH), rsp_status != nfi_pkg::ST_SENT && rsp_status != nfi_pkg::ST_STALL)
   // sequence total and latency stay zero unless a flit went out
   `NFI_ASSERT_SAME(a_idle_zero, rsp_valid && (rsp_status != nfi_pkg::ST_SENT), rsp_seq_total == '0 && rsp_latency == '0)

endmodule

bind noc_packet_to_flit_injector_core nfi_checker u_nfi_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_cmd       (req_cmd),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_seq_total (rsp_seq_total),
   .rsp_latency   (rsp_latency)
);

### sim/tb.sv
// self-checking testbench for the flit injector core: queued pushes, flit cutting, flushes
`timescale 1ns / 100ps

module tb;

   localparam int PADDR_W     = nfi_pkg::PADDR_W;
   localparam int CH_W        = nfi_pkg::CH_W;
   localparam int LEN_W       = nfi_pkg::LEN_W;
   localparam int NUM_VCS     = nfi_pkg::NUM_VCS;
   localparam int QUEUE_DEPTH = nfi_pkg::QUEUE_DEPTH;
   localparam int MAX_FLITS   = nfi_pkg::MAX_FLITS;

   localparam logic [PADDR_W-1:0] INJ_DIS_ADDR = PADDR_W'(4 * int'(nfi_pkg::REG_INJ_DIS));

   typedef struct {
      logic                cmd;
      logic [7:0]          src;
      logic [7:0]          dst;
      logic [CH_W-1:0]     ch;
      logic [31:0]         birth;
      logic [LEN_W-1:0]    len;
      logic [2:0]          kind;
      logic [31:0]         word;
      logic                ack;
      logic                ack_follow;
      logic [NUM_VCS-1:0]  mask;
      logic [31:0]         cyc;
   } nfi_cmd_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        source;
      logic [7:0]        dest;
      logic [CH_W-1:0]   channel;
      logic [31:0]       stamp;
      logic [LEN_W-1:0]  seq_index;
      logic [LEN_W-1:0]  seq_total;
      logic [1:0]        fkind;
      logic [2:0]        pkind;
      logic [31:0]       word;
      logic              req_level;
      logic [31:0]       latency;
   } flit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;

   logic                req_cmd          = 1'b0;
   logic [7:0]          req_source_node  = '0;
   logic [7:0]          req_dest_node    = '0;
   logic [CH_W-1:0]     req_channel      = '0;
   logic [31:0]         req_birth_time   = '0;
   logic [LEN_W-1:0]    req_length_flits = '0;
   logic [2:0]          req_kind         = '0;
   logic signed [31:0]  req_word         = '0;
   logic                req_ack_level    = 1'b0;
   logic [NUM_VCS-1:0]  req_full_mask    = '0;
   logic [31:0]         req_cycle_now    = '0;

   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [7:0]          rsp_flit_source;
   logic [7:0]          rsp_flit_dest;
   logic [CH_W-1:0]     rsp_flit_channel;
   logic [31:0]         rsp_flit_time;
   logic [LEN_W-1:0]    rsp_seq_index;
   logic [LEN_W-1:0]    rsp_seq_total;
   logic [1:0]          rsp_flit_kind;
   logic [2:0]          rsp_flit_payload_kind;
   logic signed [31:0]  rsp_flit_payload_word;
   logic                rsp_req_level;
   logic [31:0]         rsp_latency;

   logic                psel    = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite  = 1'b0;
   logic [PADDR_W-1:0]  paddr   = '0;
   logic [31:0]         pwdata  = '0;
   logic [31:0]         prdata;
   logic                pready;

   // predictor state
   nfi_pkg::entry_type pkt_fifo[$];
   logic [LEN_W-1:0]   flits_left = '0;
   logic               level_now = 1'b0;
   logic               inj_disabled = 1'b0;

   nfi_cmd_type        pending_q[$];
   flit_result_type    flit_expect_q[$];
   nfi_cmd_type        cur_cmd;
   flit_result_type    mon_want;
   int                 idle_left = 0;
   int                 calm_left = 0;
   int                 mismatches = 0;
   logic [31:0]        gen_time;
   logic               phase_dis [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   noc_packet_to_flit_injector_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_source_node(req_source_node), .req_dest_node(req_dest_node),
      .req_channel(req_channel), .req_birth_time(req_birth_time),
      .req_length_flits(req_length_flits), .req_kind(req_kind), .req_word(req_word),
      .req_ack_level(req_ack_level), .req_full_mask(req_full_mask),
      .req_cycle_now(req_cycle_now),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_flit_source(rsp_flit_source),
      .rsp_flit_dest(rsp_flit_dest), .rsp_flit_channel(rsp_flit_channel),
      .rsp_flit_time(rsp_flit_time), .rsp_seq_index(rsp_seq_index),
      .rsp_seq_total(rsp_seq_total), .rsp_flit_kind(rsp_flit_kind),
      .rsp_flit_payload_kind(rsp_flit_payload_kind),
      .rsp_flit_payload_word(rsp_flit_payload_word), .rsp_req_level(rsp_req_level),
      .rsp_latency(rsp_latency),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic flit_result_type compute_flit_result(nfi_cmd_type c);
      flit_result_type r;
      nfi_pkg::entry_type e;
      logic [LEN_W-1:0] left;
      r = '0;
      if (c.cmd == nfi_pkg::CMD_PUSH) begin
         if (pkt_fifo.size() >= QUEUE_DEPTH) begin
            r.status = nfi_pkg::ST_DROP;
         end else begin
            e.source  = c.src;
            e.dest    = c.dst;
            e.channel = CH_W'(c.ch % NUM_VCS);
            e.len     = (c.len == 0) ? LEN_W'(1) : c.len;
            e.stamp   = c.birth;
            e.pkind   = c.kind;
            e.word    = c.word;
            pkt_fifo  = {pkt_fifo, e};
            r.status  = nfi_pkg::ST_NONE;
         end
      end else begin
         // unstarted head while disabled: whole queue goes
         if (pkt_fifo.size() > 0 && flits_left == 0 && inj_disabled) begin
            pkt_fifo.delete();
            flits_left = '0;
         end
         if (pkt_fifo.size() > 0 && c.ack == level_now) begin
            e = pkt_fifo[0];
            if (c.mask[e.channel]) begin
               r.status  = nfi_pkg::ST_STALL;
               r.channel = e.channel;
            end else begin
               left = (flits_left == 0) ? e.len : flits_left;
               if (left == e.len)   r.fkind = nfi_pkg::FK_HEAD;
               else if (left == 1)  r.fkind = nfi_pkg::FK_TAIL;
               else                 r.fkind = nfi_pkg::FK_BODY;
               r.status    = nfi_pkg::ST_SENT;
               r.source    = e.source;
               r.dest      = e.dest;
               r.channel   = e.channel;
               r.stamp     = e.stamp;
               r.seq_index = e.len - left;
               r.seq_total = e.len;
               r.pkind     = e.pkind;
               r.word      = e.word;
               r.latency   = c.cyc - e.stamp;
               level_now   = ~level_now;
               left        = left - 1'b1;
               if (left == 0) begin
                  void'(pkt_fifo.pop_front());
                  flits_left = '0;
                  if (inj_disabled) pkt_fifo.delete();
               end else begin
                  flits_left = left;
               end
            end
         end
      end
      r.req_level = level_now;
      return r;
   endfunction

   task automatic log_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // driver: one command beat per accepted start, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) flit_expect_q = {flit_expect_q, compute_flit_result(cur_cmd)};
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_q.size() != 0) begin
               cur_cmd = pending_q.pop_front();
               if (cur_cmd.ack_follow) cur_cmd.ack = level_now;
               req_cmd          <= cur_cmd.cmd;
               req_source_node  <= cur_cmd.src;
               req_dest_node    <= cur_cmd.dst;
               req_channel      <= cur_cmd.ch;
               req_birth_time   <= cur_cmd.birth;
               req_length_flits <= cur_cmd.len;
               req_kind         <= cur_cmd.kind;
               req_word         <= cur_cmd.word;
               req_ack_level    <= cur_cmd.ack;
               req_full_mask    <= cur_cmd.mask;
               req_cycle_now    <= cur_cmd.cyc;
               start            <= 1'b1;
               // occasional stretches with back-to-back beats
               if (calm_left > 0) begin
                  calm_left--;
                  idle_left = 0;
               end else if ($urandom_range(0, 19) == 0) begin
                  calm_left = $urandom_range(20, 60);
                  idle_left = 0;
               end else begin
                  idle_left = $urandom_range(0, 6);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (flit_expect_q.size() == 0) begin
            log_mismatch("result beat with nothing expected");
         end else begin
            mon_want = flit_expect_q.pop_front();
            cmp_field("status", rsp_status, mon_want.status);
            cmp_field("flit_source", rsp_flit_source, mon_want.source);
            cmp_field("flit_dest", rsp_flit_dest, mon_want.dest);
            cmp_field("flit_channel", rsp_flit_channel, mon_want.channel);
            cmp_field("flit_time", rsp_flit_time, mon_want.stamp);
            cmp_field("seq_index", rsp_seq_index, mon_want.seq_index);
            cmp_field("seq_total", rsp_seq_total, mon_want.seq_total);
            cmp_field("flit_kind", rsp_flit_kind, mon_want.fkind);
            cmp_field("flit_payload_kind", rsp_flit_payload_kind, mon_want.pkind);
            cmp_field("flit_payload_word", rsp_flit_payload_word, mon_want.word);
            cmp_field("req_level", rsp_req_level, mon_want.req_level);
            cmp_field("latency", rsp_latency, mon_want.latency);
         end
      end
   end

   function automatic nfi_cmd_type rand_cmd();
      nfi_cmd_type c;
      c.cmd        = nfi_pkg::CMD_TICK;
      c.src        = 8'($urandom());
      c.dst        = 8'($urandom());
      c.ch         = CH_W'($urandom());
      c.birth      = $urandom();
      c.len        = LEN_W'($urandom());
      c.kind       = 3'($urandom());
      c.word       = $urandom();
      c.ack        = 1'($urandom());
      c.ack_follow = 1'b0;
      c.mask       = NUM_VCS'($urandom());
      c.cyc        = $urandom();
      return c;
   endfunction

   task automatic add_push(logic [7:0] s, logic [7:0] d, logic [CH_W-1:0] ch,
                           logic [31:0] b, logic [LEN_W-1:0] l, logic [2:0] k,
                           logic [31:0] w);
      nfi_cmd_type c;
      c         = rand_cmd();
      c.cmd     = nfi_pkg::CMD_PUSH;
      c.src     = s;
      c.dst     = d;
      c.ch      = ch;
      c.birth   = b;
      c.len     = l;
      c.kind    = k;
      c.word    = w;
      pending_q = {pending_q, c};
   endtask

   task automatic add_tick(logic follow, logic ack, logic [NUM_VCS-1:0] mask,
                           logic [31:0] cyc);
      nfi_cmd_type c;
      c            = rand_cmd();
      c.ack_follow = follow;
      c.ack        = ack;
      c.mask       = mask;
      c.cyc        = cyc;
      pending_q    = {pending_q, c};
   endtask

   task automatic gen_random_phase(int n);
      int push_pct;
      int r;
      logic [LEN_W-1:0] l;
      logic [31:0] b;
      push_pct = $urandom_range(15, 55);
      repeat (n) begin
         gen_time += $urandom_range(1, 8);
         if ($urandom_range(0, 99) < push_pct) begin
            r = $urandom_range(0, 99);
            if (r < 4)       l = '0;
            else if (r < 5)  l = LEN_W'(MAX_FLITS);
            else if (r < 8)  l = LEN_W'($urandom_range(6, 40));
            else             l = LEN_W'($urandom_range(1, 5));
            b = ($urandom_range(0, 4) == 0) ? $urandom() : gen_time - $urandom_range(0, 300);
            add_push(8'($urandom()), 8'($urandom()), CH_W'($urandom()), b, l,
                     3'($urandom()), $urandom());
         end else begin
            add_tick($urandom_range(0, 99) < 85, 1'($urandom()),
                     ($urandom_range(0, 9) < 7) ? '0 : NUM_VCS'($urandom()),
                     ($urandom_range(0, 19) == 0) ? $urandom() : gen_time);
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_q.size() != 0 || start || flit_expect_q.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write_inj_dis(logic val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= INJ_DIS_ADDR;
      pwdata  <= {31'b0, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      inj_disabled = val;
   endtask

   initial begin
      gen_time = $urandom();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_drained();
      csr_write_inj_dis(1'b0);

      // empty queue, one-flit packet, ack mismatch, stall, wrapped latency
      add_tick(1'b0, 1'b0, '0, 32'd0);
      add_push(8'hFF, 8'h00, 2'd3, 32'hFFFF_FFFF, 6'd0, 3'd7, 32'h8000_0000);
      add_tick(1'b0, 1'b1, '0, 32'd3);
      add_tick(1'b1, 1'b0, 4'b1000, 32'd4);
      add_tick(1'b1, 1'b0, 4'b0111, 32'd5);
      // three-flit packet: head, body, tail
      add_push(8'h00, 8'hFF, 2'd0, 32'h0, 6'd3, 3'd0, 32'h7FFF_FFFF);
      repeat (3) add_tick(1'b1, 1'b0, 4'b1110, 32'hFFFF_FFFF);
      // fill the queue, last push gets dropped
      for (int i = 0; i < QUEUE_DEPTH + 1; i++)
         add_push(8'($urandom()), 8'($urandom()), CH_W'($urandom()), $urandom(),
                  (i == 0) ? 6'd3 : LEN_W'($urandom_range(1, 4)), 3'($urandom()),
                  $urandom());
      add_tick(1'b1, 1'b0, 4'b0000, gen_time);
      wait_drained();

      // disabled with a started packet: finish it, then the rest is cleared
      csr_write_inj_dis(1'b1);
      add_tick(1'b1, 1'b0, 4'b1111, gen_time);
      add_tick(1'b1, 1'b0, 4'b0000, gen_time + 1);
      add_tick(1'b1, 1'b0, 4'b0000, gen_time + 2);
      add_tick(1'b1, 1'b0, 4'b0000, gen_time + 3);
      add_push(8'($urandom()), 8'($urandom()), CH_W'($urandom()), $urandom(), 6'd2,
               3'($urandom()), $urandom());
      add_tick(1'b1, 1'b0, 4'b0000, gen_time + 4);

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         csr_write_inj_dis(phase_dis[p]);
         gen_random_phase(165);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
